// ===== design/vsfe_pkg.sv =====
// Shared widths, face codes and command types of the voxel slab face emitter.
`default_nettype none
package vsfe_pkg;

	localparam int MAX_DIM  = 256;
	localparam int COORD_W  = 8;
	localparam int COLOR_W  = 8;
	localparam int MASK_W   = 6;
	localparam int Z_W      = 9;
	localparam int KIND_W   = 3;
	localparam int SIDE_N   = 4;

	// z range ends here; a voxel arriving at this z is dropped
	localparam logic [Z_W:0] Z_LIMIT = (Z_W + 1)'(255 + MAX_DIM);

	localparam int MASK_TOP_BIT = 4;
	localparam int MASK_BOT_BIT = 5;

	localparam logic [KIND_W-1:0] FACE_TOP    = 3'd0;
	localparam logic [KIND_W-1:0] FACE_XN     = 3'd1;
	localparam logic [KIND_W-1:0] FACE_XP     = 3'd2;
	localparam logic [KIND_W-1:0] FACE_YN     = 3'd3;
	localparam logic [KIND_W-1:0] FACE_YP     = 3'd4;
	localparam logic [KIND_W-1:0] FACE_BOTTOM = 3'd5;

	// slot order of one command: top, sides of the closed run, sides of the
	// final run, bottom
	localparam int N_SLOTS  = 10;
	localparam int SLOT_W   = 4;
	localparam logic [SLOT_W-1:0] SLOT_TOP = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_A0  = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_A3  = 4'd4;
	localparam logic [SLOT_W-1:0] SLOT_B0  = 4'd5;
	localparam logic [SLOT_W-1:0] SLOT_B3  = 4'd8;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	typedef struct packed {
		logic [N_SLOTS-1:0] slots;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] top_z;
		logic [COLOR_W-1:0] top_color;
		logic [Z_W-1:0]     a_z;
		logic [Z_W-1:0]     a_h;
		logic [COLOR_W-1:0] a_color;
		logic [Z_W-1:0]     b_z;
		logic [Z_W-1:0]     b_h;
		logic [COLOR_W-1:0] b_color;
		logic [Z_W-1:0]     bot_z;
		logic [COLOR_W-1:0] bot_color;
	} face_cmd_t;

	typedef struct packed {
		logic      valid;
		face_cmd_t cmd;
	} q_push_t;

	typedef struct packed {
		logic full;
		logic avail;
	} q_stat_t;

endpackage
`default_nettype wire

// ===== design/vsfe_front.sv =====
// Front end: slab and run tracking, one face command per voxel that has faces.
`default_nettype none
module vsfe_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [vsfe_pkg::COORD_W-1:0]  column_x,
	input  wire logic [vsfe_pkg::COORD_W-1:0]  column_y,
	input  wire logic [vsfe_pkg::COORD_W-1:0]  slab_top,
	input  wire logic [vsfe_pkg::COLOR_W-1:0]  voxel_color,
	input  wire logic [vsfe_pkg::MASK_W-1:0]   face_mask,
	input  wire logic                          first_voxel,
	input  wire logic                          last_voxel,
	input  wire vsfe_pkg::q_stat_t             q_stat,
	output vsfe_pkg::q_push_t                  push
);
	import vsfe_pkg::*;

	logic [COORD_W-1:0] slab_x_q, slab_y_q, nx_x, nx_y;
	logic [MASK_W-1:0]  slab_mask_q, nx_mask;
	logic [Z_W-1:0]     run_start_q, next_z_q, nx_rs, nx_nz;
	logic [COLOR_W-1:0] run_color_q, nx_rc;
	logic               in_slab_q, nx_in;
	logic               live, top_en, bot_en, accept;
	logic [SIDE_N-1:0]  a_mask, b_mask;
	face_cmd_t          cmd;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;

	always_comb begin
		nx_x    = slab_x_q;
		nx_y    = slab_y_q;
		nx_mask = slab_mask_q;
		nx_rs   = run_start_q;
		nx_rc   = run_color_q;
		nx_nz   = next_z_q;
		nx_in   = in_slab_q;
		live    = 1'b0;
		top_en  = 1'b0;
		bot_en  = 1'b0;
		a_mask  = '0;
		b_mask  = '0;
		if (first_voxel) begin
			live    = 1'b1;
			nx_in   = 1'b1;
			nx_x    = column_x;
			nx_y    = column_y;
			nx_mask = face_mask;
			nx_rs   = {1'b0, slab_top};
			nx_rc   = voxel_color;
			nx_nz   = {1'b0, slab_top} + 9'd1;
			top_en  = face_mask[MASK_TOP_BIT];
		end else if (in_slab_q) begin
			live = 1'b1;
			if ({1'b0, next_z_q} < Z_LIMIT) begin
				if (voxel_color != run_color_q) begin
					a_mask = slab_mask_q[SIDE_N-1:0];
					nx_rs  = next_z_q;
					nx_rc  = voxel_color;
				end
				nx_nz = next_z_q + 9'd1;
			end
		end
		if (live && last_voxel) begin
			b_mask = nx_mask[SIDE_N-1:0];
			bot_en = nx_mask[MASK_BOT_BIT];
			nx_in  = 1'b0;
		end

		cmd.slots     = {bot_en, b_mask, a_mask, top_en};
		cmd.x         = nx_x;
		cmd.y         = nx_y;
		cmd.top_z     = slab_top;
		cmd.top_color = voxel_color;
		cmd.a_z       = run_start_q;
		cmd.a_h       = next_z_q - run_start_q;
		cmd.a_color   = run_color_q;
		cmd.b_z       = nx_rs;
		cmd.b_h       = nx_nz - nx_rs;
		cmd.b_color   = nx_rc;
		cmd.bot_z     = nx_nz;
		cmd.bot_color = nx_rc;
	end

	assign push.valid = accept && (|cmd.slots);
	assign push.cmd   = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slab_x_q    <= '0;
			slab_y_q    <= '0;
			slab_mask_q <= '0;
			run_start_q <= '0;
			run_color_q <= '0;
			next_z_q    <= '0;
			in_slab_q   <= 1'b0;
		end else if (accept) begin
			slab_x_q    <= nx_x;
			slab_y_q    <= nx_y;
			slab_mask_q <= nx_mask;
			run_start_q <= nx_rs;
			run_color_q <= nx_rc;
			next_z_q    <= nx_nz;
			in_slab_q   <= nx_in;
		end
	end

endmodule
`default_nettype wire

// ===== design/vsfe_queue.sv =====
// Short command queue between front end and face sequencer.
`default_nettype none
module vsfe_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire vsfe_pkg::q_push_t   push,
	input  wire logic                pop,
	output vsfe_pkg::q_stat_t        q_stat,
	output vsfe_pkg::face_cmd_t      head
);
	import vsfe_pkg::*;

	face_cmd_t         mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]     count_q;
	logic              do_push, do_pop;

	assign q_stat.full  = (count_q == (Q_AW + 1)'(Q_DEPTH));
	assign q_stat.avail = (count_q != '0);
	assign head         = mem_q[rd_ptr_q];
	assign do_push      = push.valid && !q_stat.full;
	assign do_pop       = pop && q_stat.avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/vsfe_back.sv =====
// Face sequencer: walks one command's slots, one face per cycle unless stalled.
`default_nettype none
module vsfe_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire vsfe_pkg::q_stat_t             q_stat,
	input  wire vsfe_pkg::face_cmd_t           head,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [vsfe_pkg::KIND_W-1:0]        face_kind,
	output logic [vsfe_pkg::COORD_W-1:0]       face_x,
	output logic [vsfe_pkg::COORD_W-1:0]       face_y,
	output logic [vsfe_pkg::Z_W-1:0]           face_z,
	output logic [vsfe_pkg::Z_W-1:0]           face_height,
	output logic [vsfe_pkg::COLOR_W-1:0]       face_color,
	output logic                               last_of_item
);
	import vsfe_pkg::*;

	face_cmd_t           cur_q;
	logic [N_SLOTS-1:0]  pend_q, pend_clr;
	logic [SLOT_W-1:0]   sel;
	logic                have, out_free, adv;
	logic [KIND_W-1:0]   kind_d;
	logic [Z_W-1:0]      z_d, h_d;
	logic [COLOR_W-1:0]  color_d;

	logic                out_valid_q, last_q;
	logic [KIND_W-1:0]   kind_q;
	logic [COORD_W-1:0]  x_q, y_q;
	logic [Z_W-1:0]      z_q, h_q;
	logic [COLOR_W-1:0]  color_q;

	// lowest pending slot goes first
	always_comb begin
		sel = '0;
		for (int i = N_SLOTS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel = SLOT_W'(i);
			end
		end
		pend_clr      = pend_q;
		pend_clr[sel] = 1'b0;
	end

	always_comb begin
		if (sel == SLOT_TOP) begin
			kind_d  = FACE_TOP;
			z_d     = {1'b0, cur_q.top_z};
			h_d     = '0;
			color_d = cur_q.top_color;
		end else if (sel <= SLOT_A3) begin
			kind_d  = FACE_XN + KIND_W'(sel - SLOT_A0);
			z_d     = cur_q.a_z;
			h_d     = cur_q.a_h;
			color_d = cur_q.a_color;
		end else if (sel <= SLOT_B3) begin
			kind_d  = FACE_XN + KIND_W'(sel - SLOT_B0);
			z_d     = cur_q.b_z;
			h_d     = cur_q.b_h;
			color_d = cur_q.b_color;
		end else begin
			kind_d  = FACE_BOTTOM;
			z_d     = cur_q.bot_z;
			h_d     = '0;
			color_d = cur_q.bot_color;
		end
	end

	assign have     = |pend_q;
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = have && out_free;
	assign pop      = q_stat.avail && (!have || (adv && (pend_clr == '0)));

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (adv) begin
			kind_q  <= kind_d;
			x_q     <= cur_q.x;
			y_q     <= cur_q.y;
			z_q     <= z_d;
			h_q     <= h_d;
			color_q <= color_d;
			last_q  <= (pend_clr == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pend_q <= head.slots;
			end else if (adv) begin
				pend_q <= pend_clr;
			end
			if (out_free) begin
				out_valid_q <= adv;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign face_kind    = kind_q;
	assign face_x       = x_q;
	assign face_y       = y_q;
	assign face_z       = z_q;
	assign face_height  = h_q;
	assign face_color   = color_q;
	assign last_of_item = last_q;

endmodule
`default_nettype wire

// ===== design/voxel_slab_face_emitter.sv =====
// Top level of the voxel slab face emitter: front end, command queue, face sequencer.
//
//  channel | beat                                   | handshake
//  --------+----------------------------------------+--------------------
//  voxel   | column_x/y, slab_top, voxel_color,     | in_valid, in_stall
//          | face_mask, first_voxel, last_voxel     |
//  face    | face_kind/x/y/z/height/color,          | out_valid, out_stall
//          | last_of_item                           |
//
// Cycles: the front end takes one voxel beat per cycle while the 4-entry
//   command queue has room; the face sequencer sends one face per cycle while
//   out_stall is low, and a voxel yields 0 to 9 faces.
// Path: queue, sequencer command register, then output register.
// Reset: arst_n clears slab tracking, queue pointers and output valid; no
//   memory, no clearing pass.
// Stalls: out_stall holds the output register; the sequencer and then the
//   queue fill up, and in_stall rises only once the queue is full.
`default_nettype none
module voxel_slab_face_emitter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [vsfe_pkg::COORD_W-1:0]  column_x,
	input  wire logic [vsfe_pkg::COORD_W-1:0]  column_y,
	input  wire logic [vsfe_pkg::COORD_W-1:0]  slab_top,
	input  wire logic [vsfe_pkg::COLOR_W-1:0]  voxel_color,
	input  wire logic [vsfe_pkg::MASK_W-1:0]   face_mask,
	input  wire logic                          first_voxel,
	input  wire logic                          last_voxel,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [vsfe_pkg::KIND_W-1:0]        face_kind,
	output logic [vsfe_pkg::COORD_W-1:0]       face_x,
	output logic [vsfe_pkg::COORD_W-1:0]       face_y,
	output logic [vsfe_pkg::Z_W-1:0]           face_z,
	output logic [vsfe_pkg::Z_W-1:0]           face_height,
	output logic [vsfe_pkg::COLOR_W-1:0]       face_color,
	output logic                               last_of_item
);
	import vsfe_pkg::*;

	q_push_t   push;
	q_stat_t   q_stat;
	face_cmd_t head;
	logic      pop;

	// front end: tracks the open slab and run, one command per voxel with faces
	vsfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.column_x    (column_x),
		.column_y    (column_y),
		.slab_top    (slab_top),
		.voxel_color (voxel_color),
		.face_mask   (face_mask),
		.first_voxel (first_voxel),
		.last_voxel  (last_voxel),
		.q_stat      (q_stat),
		.push        (push)
	);

	// decouples voxel intake from face output
	vsfe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.q_stat (q_stat),
		.head   (head)
	);

	// back end: expands a command into its faces, output register included
	vsfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.face_kind    (face_kind),
		.face_x       (face_x),
		.face_y       (face_y),
		.face_z       (face_z),
		.face_height  (face_height),
		.face_color   (face_color),
		.last_of_item (last_of_item)
	);

`ifndef NO_ASSERTIONS
	// front end never pushes a command into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !q_stat.full)
		else $error("command pushed into full queue");

	// sequencer never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.avail)
		else $error("pop from empty queue");

	// top and bottom faces are planes: no height
	a_plane_height: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (face_kind == FACE_TOP || face_kind == FACE_BOTTOM)
		|-> face_height == '0)
		else $error("top or bottom face with nonzero height");

	// voxel side stalls only when the queue is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_stat.full)
		else $error("input stalled with room in queue");
`endif

endmodule
`default_nettype wire
